FILE: src/gmps_pkg.sv
// gmps_pkg: shared constants and types for the grid max path sum unit.
// No dependencies; imported by the channel interfaces and all modules.
package gmps_pkg;

    localparam int ROWS_MAX   = 1024;
    localparam int COLS_MAX   = 4096;
    localparam int ROW_W      = $clog2(ROWS_MAX);
    localparam int COL_W      = $clog2(COLS_MAX);
    localparam int ROW_CNT_W  = 11;
    localparam int COL_CNT_W  = 13;
    localparam int CELL_W     = 16;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    typedef logic signed [CELL_W-1:0] t_cell;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [COL_W-1:0]         t_col;

    typedef struct packed {
        logic       valid;
        logic [1:0] count;
    } t_fifo_stat;

endpackage

FILE: src/gmps_cell_if.sv
// gmps_cell_if: valid/ready channel carrying one grid cell item.
// Depends on gmps_pkg.
interface gmps_cell_if;
    import gmps_pkg::*;
    logic  valid;
    logic  ready;
    t_cell cell_value;
    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

FILE: src/gmps_result_if.sv
// gmps_result_if: valid/ready channel carrying one result item.
// Depends on gmps_pkg.
interface gmps_result_if;
    import gmps_pkg::*;
    logic valid;
    logic ready;
    t_sum max_gold;
    modport source (output valid, output max_gold, input ready);
    modport sink   (input valid, input max_gold, output ready);
endinterface

FILE: src/gmps_res_fifo.sv
// gmps_res_fifo: two-entry result queue in front of the result channel.
// Depends on gmps_pkg.
module gmps_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gmps_pkg::t_sum    i_data,
    input  logic              i_pop,
    output gmps_pkg::t_fifo_stat o_stat,
    output gmps_pkg::t_sum    o_data
);
    import gmps_pkg::*;

    t_sum       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop_ok;

    assign pop_ok = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.count = r_cnt;
    assign o_data       = r_mem[r_rp];

endmodule

FILE: src/grid_max_path_sum_dp_unit.sv
// grid_max_path_sum_dp_unit: top level of the grid max path sum unit.
// Depends on gmps_pkg, gmps_cell_if, gmps_result_if and gmps_res_fifo.
//
// Usage:
//   Cells enter on i_cell in column-major order, rows 0..n-1 of each column.
//   One cell item is taken per cycle while i_cell.ready is high. After the
//   final cell of the grid one item carrying the largest path sum of the last
//   column leaves on o_result, registered through stage 1 and the result buffer.
//   Throughput is one cell per cycle: the column store is read one row ahead
//   through its single registered read port and written once per cell, with
//   a bypass for an entry written in the same cycle it is read.
//   Row and column counts are written on the config port while idle; a write
//   restarts the grid. Zero counts act as 1, counts above the maxima saturate.
//   Reset sets both counts to 1 and restarts the grid; no clearing pass runs.
//   Results queue in a two-entry buffer; when o_result stalls and the buffer
//   plus the cell in flight would overflow it, i_cell.ready drops until the
//   receiver takes an item.
module grid_max_path_sum_dp_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gmps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gmps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    gmps_cell_if.sink                           i_cell,
    gmps_result_if.source                       o_result
);
    import gmps_pkg::*;

    // configuration, held as last index
    t_row r_row_max;
    t_col r_col_max;
    logic [ROW_CNT_W-1:0] cfg_rows;
    logic [COL_CNT_W-1:0] cfg_cols;

    // position of the next cell
    t_row r_row;
    t_col r_col;

    // column store
    t_sum r_store [ROWS_MAX];
    t_sum r_rdata;
    t_row raddr;
    logic r_fwd_hit;
    t_sum r_fwd_data;

    // compute stage
    logic  r_s1_valid;
    t_row  r_s1_row;
    logic  r_s1_top;
    logic  r_s1_last_row;
    logic  r_s1_first_col;
    logic  r_s1_last_col;
    t_cell r_s1_value;

    t_sum r_cur;
    t_sum r_held;
    t_sum r_best;

    t_sum lower;
    t_sum best;
    t_sum sum;
    t_sum res_val;
    logic res_push;

    logic accept;
    logic last_row;
    logic last_col;

    t_fifo_stat fifo_stat;
    t_sum       fifo_data;
    logic       pop;
    logic [1:0] pend;

    assign cfg_rows = i_cfg_data[ROW_CNT_W-1:0];
    assign cfg_cols = i_cfg_data[COL_CNT_W-1:0];

    assign last_row = (r_row == r_row_max);
    assign last_col = (r_col == r_col_max);
    assign raddr    = last_row ? '0 : t_row'(r_row + 1'b1);

    assign pop  = fifo_stat.valid && o_result.ready;
    assign pend = fifo_stat.count + {1'b0, r_s1_valid && r_s1_last_row && r_s1_last_col}
                  - {1'b0, pop};
    assign i_cell.ready = (pend < 2'd2);
    assign accept       = i_cell.valid && i_cell.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_max <= '0;
            r_col_max <= '0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_COUNT: begin
                    if (cfg_rows == '0) begin
                        r_row_max <= '0;
                    end else if (cfg_rows > ROW_CNT_W'(ROWS_MAX)) begin
                        r_row_max <= t_row'(ROWS_MAX - 1);
                    end else begin
                        r_row_max <= t_row'(cfg_rows - 1'b1);
                    end
                    r_row <= '0;
                    r_col <= '0;
                end
                CFG_COLUMN_COUNT: begin
                    if (cfg_cols == '0) begin
                        r_col_max <= '0;
                    end else if (cfg_cols > COL_CNT_W'(COLS_MAX)) begin
                        r_col_max <= t_col'(COLS_MAX - 1);
                    end else begin
                        r_col_max <= t_col'(cfg_cols - 1'b1);
                    end
                    r_row <= '0;
                    r_col <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (last_row) begin
                r_row <= '0;
                r_col <= last_col ? '0 : t_col'(r_col + 1'b1);
            end else begin
                r_row <= t_row'(r_row + 1'b1);
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_row       <= r_row;
            r_s1_top       <= (r_row == '0);
            r_s1_last_row  <= last_row;
            r_s1_first_col <= (r_col == '0);
            r_s1_last_col  <= last_col;
            r_s1_value     <= i_cell.cell_value;
        end
    end

    // column store: registered read one row ahead, write from stage 1
    always_ff @(posedge i_clk) begin
        r_rdata <= r_store[raddr];
        if (r_s1_valid) begin
            r_store[r_s1_row] <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= r_s1_valid && (r_s1_row == raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= sum;
    end

    assign lower = r_fwd_hit ? r_fwd_data : r_rdata;

    always_comb begin
        best = r_cur;
        if (!r_s1_top && (r_held > best)) begin
            best = r_held;
        end
        if (!r_s1_last_row && (lower > best)) begin
            best = lower;
        end
    end

    assign sum = r_s1_first_col ? t_sum'(r_s1_value) : t_sum'(r_s1_value) + best;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_held <= r_cur;
            r_cur  <= (r_row_max == '0) ? sum : lower;
        end
    end

    assign res_val  = (r_s1_top || (sum > r_best)) ? sum : r_best;
    assign res_push = r_s1_valid && r_s1_last_row && r_s1_last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (r_s1_valid && r_s1_last_col) begin
            r_best <= res_val;
        end
    end

    gmps_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_val),
        .i_pop   (pop),
        .o_stat  (fifo_stat),
        .o_data  (fifo_data)
    );

    assign o_result.valid    = fifo_stat.valid;
    assign o_result.max_gold = fifo_data;

endmodule

FILE: test/tb_grid_max_path_sum_dp_unit.sv
// tb_grid_max_path_sum_dp_unit: self-checking bench for the grid max path sum unit.
// Streams directed and random grids, predicts each grid's best last-column sum.
// Depends on gmps_pkg, gmps_cell_if, gmps_result_if and grid_max_path_sum_dp_unit.
module tb_grid_max_path_sum_dp_unit;
    import gmps_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_CELLS  = 300;
    localparam int RANDOM_GRIDS  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    class gold_path_scoreboard;
        t_sum                 col_store[ROWS_MAX];
        logic [ROW_CNT_W-1:0] rows_reg;
        logic [COL_CNT_W-1:0] cols_reg;
        int unsigned          row_pos;
        int unsigned          col_pos;
        t_sum                 upper_hold;
        t_sum                 best_last;
        t_sum                 expected_max_gold[$];
        int                   error_count;

        function new();
            rows_reg    = 1;
            cols_reg    = 1;
            error_count = 0;
            foreach (col_store[i]) col_store[i] = '0;
            restart();
        endfunction

        function void restart();
            row_pos    = 0;
            col_pos    = 0;
            upper_hold = '0;
            best_last  = '0;
        endfunction

        function int unsigned eff_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > ROWS_MAX) return ROWS_MAX;
            return rows_reg;
        endfunction

        function int unsigned eff_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > COLS_MAX) return COLS_MAX;
            return cols_reg;
        endfunction

        function int unsigned grid_size();
            return eff_rows() * eff_cols();
        endfunction

        function void note_count_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROW_COUNT) begin
                rows_reg = data[ROW_CNT_W-1:0];
                restart();
            end else if (idx == CFG_COLUMN_COUNT) begin
                cols_reg = data[COL_CNT_W-1:0];
                restart();
            end
        endfunction

        function void note_cell(t_cell v);
            int unsigned n;
            int unsigned m;
            t_sum        old;
            t_sum        best;
            t_sum        s;
            n   = eff_rows();
            m   = eff_cols();
            old = col_store[row_pos];
            if (col_pos == 0) begin
                s = t_sum'(v);
            end else begin
                best = old;
                if (row_pos > 0 && upper_hold > best) best = upper_hold;
                if (row_pos + 1 < n && col_store[row_pos+1] > best) best = col_store[row_pos+1];
                s = t_sum'(v) + best;
            end
            upper_hold         = old;
            col_store[row_pos] = s;
            if (col_pos + 1 == m && (row_pos == 0 || s > best_last)) best_last = s;
            if (row_pos + 1 < n) begin
                row_pos++;
            end else if (col_pos + 1 < m) begin
                row_pos    = 0;
                col_pos++;
                upper_hold = '0;
            end else begin
                expected_max_gold.push_back(best_last);
                restart();
            end
        endfunction

        function void check_max_gold(t_sum got);
            t_sum want;
            if (expected_max_gold.size() == 0) begin
                $display("%0t: unexpected max_gold item, actual %0d", $time, got);
                error_count++;
                return;
            end
            want = expected_max_gold.pop_front();
            if (got !== want) begin
                $display("%0t: max_gold mismatch, expected %0d actual %0d", $time, want, got);
                error_count++;
            end
        endfunction

        function void check_drained();
            foreach (expected_max_gold[i]) begin
                $display("%0t: max_gold never arrived, expected %0d actual none",
                         $time, expected_max_gold[i]);
                error_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gmps_cell_if   cell_ch();
    gmps_result_if result_ch();

    gold_path_scoreboard sb = new();

    bit          no_idle;
    int unsigned hold_req;
    int unsigned hold_ack;
    int unsigned hold_left;
    int unsigned cycle_count = 0;

    grid_max_path_sum_dp_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cell     (cell_ch),
        .o_result   (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD/2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_grid_max_path_sum_dp_unit NOT OK");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        hold_ack        = 0;
        hold_left       = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_ack != hold_req) begin
                hold_ack        = hold_req;
                hold_left       = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= no_idle || ($urandom_range(99) >= 8);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) sb.check_max_gold(result_ch.max_gold);
    end

    task automatic send_cell(t_cell v);
        while (!no_idle && $urandom_range(99) < 8) begin
            cell_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_value <= v;
        do @(posedge i_clk); while (!cell_ch.ready);
        sb.note_cell(v);
        @(negedge i_clk);
    endtask

    function automatic t_cell random_cell();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return t_cell'($urandom_range(65535));
    endfunction

    task automatic send_cells(int unsigned count);
        repeat (count) send_cell(random_cell());
    endtask

    task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cell_ch.valid <= 1'b0;
        cfg_we        <= 1'b1;
        cfg_idx       <= idx;
        cfg_data      <= data;
        @(posedge i_clk);
        sb.note_count_write(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // sender pauses until all results are back and the pipeline has settled
    task automatic wait_drained();
        cell_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_max_gold.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_grid(logic [CFG_DATA_W-1:0] rows_data, logic [CFG_DATA_W-1:0] cols_data);
        wait_drained();
        if ($urandom_range(1)) begin
            write_count(CFG_ROW_COUNT, rows_data);
            write_count(CFG_COLUMN_COUNT, cols_data);
        end else begin
            write_count(CFG_COLUMN_COUNT, cols_data);
            write_count(CFG_ROW_COUNT, rows_data);
        end
    endtask

    initial begin
        int                    grid3_vals[9];
        int                    edge_vals[4];
        int unsigned           random_cells;
        int unsigned           random_grids;
        int unsigned           rows;
        int unsigned           cols;
        int unsigned           size;
        logic [CFG_DATA_W-1:0] rows_data;
        logic [CFG_DATA_W-1:0] cols_data;

        grid3_vals         = '{5, -32768, 7, -1, 32767, -32768, 0, 100, -5};
        edge_vals          = '{32767, -32768, 0, -1};
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        cell_ch.valid      = 1'b0;
        cell_ch.cell_value = '0;
        no_idle            = 1'b0;
        hold_req           = 0;
        random_cells       = 0;
        random_grids       = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset counts give a 1x1 grid: every cell is its own result
        foreach (edge_vals[i]) send_cell(t_cell'(edge_vals[i]));

        set_grid(13'd3, 13'd3);
        foreach (grid3_vals[i]) send_cell(t_cell'(grid3_vals[i]));

        // zero counts act as one
        set_grid(13'd0, 13'd0);
        send_cell(16'sd12345);

        // config write mid-grid restarts the grid
        set_grid(13'd2, 13'd2);
        send_cell(16'sd300);
        send_cell(-16'sd20);
        send_cell(16'sd7);
        wait_drained();
        write_count(CFG_COLUMN_COUNT, 13'd2);
        send_cell(-16'sd1);
        send_cell(16'sd2);
        send_cell(16'sd32767);
        send_cell(-16'sd32768);

        // long receiver hold-off on a 1x1 grid fills the result buffer
        set_grid(13'd1, 13'd1);
        hold_req++;
        send_cells(24);

        while (random_cells < RANDOM_CELLS || random_grids < RANDOM_GRIDS) begin
            case ($urandom_range(9))
                0: begin
                    rows = 1;
                    cols = $urandom_range(1, 12);
                end
                1: begin
                    rows = $urandom_range(1, 12);
                    cols = 1;
                end
                2: begin
                    rows = $urandom_range(0, 5);
                    cols = $urandom_range(0, 5);
                end
                default: begin
                    rows = $urandom_range(2, 8);
                    cols = $urandom_range(2, 8);
                end
            endcase
            rows_data = {2'($urandom_range(3)), 11'(rows)};
            cols_data = 13'(cols);
            no_idle   = ($urandom_range(7) == 0);
            set_grid(rows_data, cols_data);
            size = sb.grid_size();
            if (size > 1 && $urandom_range(3) == 0) begin
                send_cells($urandom_range(1, size - 1));
                wait_drained();
                write_count(CFG_COLUMN_COUNT, cols_data);
            end
            repeat ($urandom_range(1, 4)) begin
                send_cells(size);
                random_cells += size;
                random_grids++;
            end
        end
        no_idle = 1'b0;

        // long stretch with no idling on either side
        no_idle = 1'b1;
        set_grid(13'd8, 13'd8);
        send_cells(sb.grid_size());
        no_idle = 1'b0;

        // oversized counts saturate; partial grids, then a restart
        set_grid(13'h1FFF, 13'd1);
        send_cells(32);
        set_grid(13'd2, 13'h1FFF);
        send_cells(32);
        set_grid(13'd3, 13'd3);
        send_cells(sb.grid_size());

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.error_count == 0) begin
            $display("tb_grid_max_path_sum_dp_unit OK");
        end else begin
            $display("tb_grid_max_path_sum_dp_unit NOT OK");
        end
        $finish;
    end

endmodule
